// ===== src/llcg_pkg.sv =====
// ----------------------------------------------------------------------------
// llcg_pkg: shared types and constants of the log level command gate
// Holds the result codes, the operation passed from the parser to the gate
// and the character decode helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package llcg_pkg;

  localparam int unsigned LEVEL_W = 4;
  localparam int unsigned OUT_COUNT_W = 32;

  localparam logic [LEVEL_W-1:0] START_RESET = 4'd6;

  // result kind
  localparam logic KIND_CMD = 1'b0;
  localparam logic KIND_LOG = 1'b1;

  // command status
  localparam logic [1:0] STATUS_IGNORED = 2'd0;
  localparam logic [1:0] STATUS_APPLIED = 2'd1;
  localparam logic [1:0] STATUS_MALFORMED = 2'd2;

  // characters of the command syntax
  localparam logic [7:0] CH_L = 8'h4c;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL = 8'h00;

  // one operation from the parser to the gate
  typedef struct packed {
    logic                kind;
    logic [1:0]          status;
    logic                apply_l;
    logic                apply_c;
    logic [LEVEL_W-1:0]  value;   // new level for a command, severity for a log beat
  } llcg_op_t;

  // decode one hex character: bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] res;
    res = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      res = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      res = {1'b1, c[3:0] + 4'd9};
    end
    return res;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage

`default_nettype wire

// ===== src/llcg_front.sv =====
// ----------------------------------------------------------------------------
// llcg_front: command parser and classifier
// Walks command strings one byte per beat and turns each log request or
// terminated command into one operation for the gate.
// ----------------------------------------------------------------------------
`default_nettype none

module llcg_front #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    accept,
  input  wire logic                    mode,
  input  wire logic [7:0]              data_byte,
  input  wire logic                    last,
  input  wire logic [3:0]              severity,
  output      logic                    op_push,
  output      llcg_pkg::llcg_op_t      op,
  output      logic [COUNT_BITS-1:0]   op_count
);

  localparam logic [3:0] PH_EXPECT   = 4'd0;
  localparam logic [3:0] PH_L_SP     = 4'd1;
  localparam logic [3:0] PH_L_HEX    = 4'd2;
  localparam logic [3:0] PH_C_SP     = 4'd3;
  localparam logic [3:0] PH_C_HEX    = 4'd4;
  localparam logic [3:0] PH_C_SP2    = 4'd5;
  localparam logic [3:0] PH_C_DIG0   = 4'd6;
  localparam logic [3:0] PH_C_DIGS   = 4'd7;
  localparam logic [3:0] PH_DONE_IGN = 4'd8;
  localparam logic [3:0] PH_DONE_BAD = 4'd9;
  localparam logic [3:0] PH_DONE_L   = 4'd10;
  localparam logic [3:0] PH_DONE_C   = 4'd11;

  logic [3:0]            phase_r, phase_nxt;
  logic [3:0]            lvl_r, lvl_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;

  logic [3:0]            ph1;
  logic [3:0]            lvl1;
  logic [COUNT_BITS-1:0] cnt1;
  logic [3:0]            ph_end;
  logic [4:0]            hex;
  logic [COUNT_BITS-1:0] digit;

  assign hex   = llcg_pkg::hex_decode(data_byte);
  assign digit = {{(COUNT_BITS-4){1'b0}}, data_byte[3:0]};

  // advance the parser by one character
  always_comb begin
    ph1  = phase_r;
    lvl1 = lvl_r;
    cnt1 = cnt_r;
    unique case (phase_r)
      PH_L_SP: begin
        ph1 = (data_byte == llcg_pkg::CH_SPACE) ? PH_L_HEX : PH_DONE_BAD;
      end
      PH_L_HEX: begin
        if (hex[4]) begin
          lvl1 = hex[3:0];
          ph1  = PH_DONE_L;
        end else begin
          ph1 = PH_DONE_BAD;
        end
      end
      PH_C_SP: begin
        ph1 = (data_byte == llcg_pkg::CH_SPACE) ? PH_C_HEX : PH_DONE_BAD;
      end
      PH_C_HEX: begin
        if (hex[4]) begin
          lvl1 = hex[3:0];
          ph1  = PH_C_SP2;
        end else begin
          ph1 = PH_DONE_BAD;
        end
      end
      PH_C_SP2: begin
        ph1 = (data_byte == llcg_pkg::CH_SPACE) ? PH_C_DIG0 : PH_DONE_BAD;
      end
      PH_C_DIG0: begin
        if (llcg_pkg::is_digit(data_byte)) begin
          cnt1 = digit;
          ph1  = PH_C_DIGS;
        end else begin
          ph1 = PH_DONE_BAD;
        end
      end
      PH_C_DIGS: begin
        if (llcg_pkg::is_digit(data_byte)) begin
          cnt1 = (cnt_r << 3) + (cnt_r << 1) + digit;
        end else begin
          ph1 = (data_byte == llcg_pkg::CH_NUL) ? PH_DONE_C : PH_DONE_BAD;
        end
      end
      PH_DONE_IGN, PH_DONE_BAD, PH_DONE_L, PH_DONE_C: begin
        ph1 = phase_r;
      end
      default: begin
        // expect command letter
        if (data_byte == llcg_pkg::CH_L) begin
          ph1 = PH_L_SP;
        end else if (data_byte == llcg_pkg::CH_C) begin
          ph1 = PH_C_SP;
        end else begin
          ph1 = PH_DONE_IGN;
        end
      end
    endcase
  end

  // close the string as if a zero byte followed
  always_comb begin
    unique case (ph1)
      PH_DONE_IGN, PH_DONE_BAD, PH_DONE_L, PH_DONE_C: ph_end = ph1;
      PH_C_DIGS:                                      ph_end = PH_DONE_C;
      PH_EXPECT:                                      ph_end = PH_DONE_IGN;
      default:                                        ph_end = PH_DONE_BAD;
    endcase
  end

  // classify the beat into an operation
  always_comb begin
    op         = '0;
    op_count   = cnt1;
    op_push    = accept && (mode || last);
    if (mode) begin
      op.kind  = llcg_pkg::KIND_LOG;
      op.value = severity;
    end else begin
      op.kind  = llcg_pkg::KIND_CMD;
      op.value = lvl1;
      unique case (ph_end)
        PH_DONE_L: begin
          op.status  = llcg_pkg::STATUS_APPLIED;
          op.apply_l = 1'b1;
        end
        PH_DONE_C: begin
          op.status  = llcg_pkg::STATUS_APPLIED;
          op.apply_c = 1'b1;
        end
        PH_DONE_BAD: op.status = llcg_pkg::STATUS_MALFORMED;
        default:     op.status = llcg_pkg::STATUS_IGNORED;
      endcase
    end
  end

  // hold parse state between command beats, restart after the last one
  always_comb begin
    phase_nxt = phase_r;
    lvl_nxt   = lvl_r;
    cnt_nxt   = cnt_r;
    if (accept && !mode) begin
      if (last) begin
        phase_nxt = PH_EXPECT;
        lvl_nxt   = '0;
        cnt_nxt   = '0;
      end else begin
        phase_nxt = ph1;
        lvl_nxt   = lvl1;
        cnt_nxt   = cnt1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_EXPECT;
      lvl_r   <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      lvl_r   <= lvl_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/llcg_queue.sv =====
// ----------------------------------------------------------------------------
// llcg_queue: two-entry operation queue
// Decouples the parser from the gate so each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module llcg_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output      logic             full,
  output      logic             not_empty,
  output      logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       fill_r, fill_nxt;

  assign full      = (fill_r == 2'd2);
  assign not_empty = (fill_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  // advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/llcg_back.sv =====
// ----------------------------------------------------------------------------
// llcg_back: severity gate and level store
// Executes queued operations against the levels and the message count and
// holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module llcg_back #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [3:0]             cfg_wr_data,
  input  wire logic                   op_valid,
  input  wire llcg_pkg::llcg_op_t     op,
  input  wire logic [COUNT_BITS-1:0]  op_count,
  output      logic                   op_pop,
  output      logic                   out_valid,
  input  wire logic                   out_stall,
  output      logic                   out_kind,
  output      logic [1:0]             out_status,
  output      logic                   out_publish,
  output      logic [3:0]             out_topic_index,
  output      logic [3:0]             out_effective_level,
  output      logic [llcg_pkg::OUT_COUNT_W-1:0] out_remaining_count
);

  logic [3:0]            base_r, base_nxt;
  logic [3:0]            counted_r, counted_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;

  logic                  valid_r, valid_nxt;
  logic                  kind_r;
  logic [1:0]            status_r;
  logic                  publish_r;
  logic [3:0]            topic_r;
  logic [3:0]            eff_r;
  logic [llcg_pkg::OUT_COUNT_W-1:0] rem_r;

  logic                  slot_free;
  logic [3:0]            active;
  logic                  pass;

  assign slot_free = !valid_r || !out_stall;
  assign op_pop    = op_valid && slot_free;
  assign active    = (count_r != '0) ? counted_r : base_r;
  assign pass      = (op.value <= active);

  // apply the operation or a register write to the level store
  always_comb begin
    base_nxt    = base_r;
    counted_nxt = counted_r;
    count_nxt   = count_r;
    if (op_pop) begin
      if (op.kind == llcg_pkg::KIND_LOG) begin
        if (pass && count_r != '0) begin
          count_nxt = count_r - COUNT_BITS'(1);
        end
      end else begin
        if (op.apply_l) begin
          base_nxt = op.value;
        end
        if (op.apply_c) begin
          counted_nxt = op.value;
          count_nxt   = op_count;
        end
      end
    end
    if (cfg_wr_en) begin
      base_nxt    = cfg_wr_data;
      counted_nxt = cfg_wr_data;
      count_nxt   = '0;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (slot_free) begin
      valid_nxt = op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= llcg_pkg::START_RESET;
      counted_r <= llcg_pkg::START_RESET;
      count_r   <= '0;
      valid_r   <= 1'b0;
    end else begin
      base_r    <= base_nxt;
      counted_r <= counted_nxt;
      count_r   <= count_nxt;
      valid_r   <= valid_nxt;
    end
  end

  // load the result beat
  always_ff @(posedge clk) begin
    if (op_pop) begin
      kind_r    <= op.kind;
      status_r  <= (op.kind == llcg_pkg::KIND_LOG) ? llcg_pkg::STATUS_IGNORED : op.status;
      publish_r <= (op.kind == llcg_pkg::KIND_LOG) && pass;
      topic_r   <= (op.kind == llcg_pkg::KIND_LOG) ? op.value : 4'd0;
      eff_r     <= (count_nxt != '0) ? counted_nxt : base_nxt;
      rem_r     <= llcg_pkg::OUT_COUNT_W'(count_nxt);
    end
  end

  assign out_valid           = valid_r;
  assign out_kind            = kind_r;
  assign out_status          = status_r;
  assign out_publish         = publish_r;
  assign out_topic_index     = topic_r;
  assign out_effective_level = eff_r;
  assign out_remaining_count = rem_r;

endmodule

`default_nettype wire

// ===== src/log_level_command_gate.sv =====
// ----------------------------------------------------------------------------
// log_level_command_gate: severity gate with a byte-serial command parser
// Input beats carry either one command character (in_mode 0) or one log
// request (in_mode 1). Commands "L <hex>" and "C <hex> <decimal>" end at a
// zero byte or at the beat marked in_last; the in_last beat yields a status result.
// Each log request yields a decision result with the level in force after it.
// cfg_wr_en/cfg_wr_data load both levels and clear the message count; write
// only while no beat is in flight.
// Throughput: one beat per cycle on each channel while no stall holds it; the
// parser decodes a beat in the cycle it is offered and the gate executes one
// operation per cycle. A beat that yields a result is written into the queue
// when it is accepted; the gate pops it and loads its result into the output
// register, which drives out_valid.
// Reset: levels at 6, count zero, parser waiting for a command letter, queue
// and output register empty.
// Stall: out_stall holds the output beat; the queue fills and in_stall rises
// once it holds two operations. No beat is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module log_level_command_gate #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [3:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic        in_mode,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last,
  input  wire logic [3:0]  in_severity,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        out_kind,
  output      logic [1:0]  out_status,
  output      logic        out_publish,
  output      logic [3:0]  out_topic_index,
  output      logic [3:0]  out_effective_level,
  output      logic [llcg_pkg::OUT_COUNT_W-1:0] out_remaining_count
);

  localparam int unsigned Q_W = $bits(llcg_pkg::llcg_op_t) + COUNT_BITS;

  logic                  accept;
  logic                  push;
  llcg_pkg::llcg_op_t    f_op;
  logic [COUNT_BITS-1:0] f_count;
  logic                  q_full;
  logic                  q_not_empty;
  logic [Q_W-1:0]        q_head;
  logic                  pop;
  llcg_pkg::llcg_op_t    b_op;
  logic [COUNT_BITS-1:0] b_count;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  llcg_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .mode      (in_mode),
    .data_byte (in_data_byte),
    .last      (in_last),
    .severity  (in_severity),
    .op_push   (push),
    .op        (f_op),
    .op_count  (f_count)
  );

  llcg_queue #(.WIDTH(Q_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({f_op, f_count}),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  assign b_op    = q_head[Q_W-1 -: $bits(llcg_pkg::llcg_op_t)];
  assign b_count = q_head[COUNT_BITS-1:0];

  llcg_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .op_valid            (q_not_empty),
    .op                  (b_op),
    .op_count            (b_count),
    .op_pop              (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_status          (out_status),
    .out_publish         (out_publish),
    .out_topic_index     (out_topic_index),
    .out_effective_level (out_effective_level),
    .out_remaining_count (out_remaining_count)
  );

endmodule

`default_nettype wire
